// ===== design/mmm_pkg.sv =====
// Shared types and constants of the matrix multiply block.
package mmm_pkg;

    localparam int DIM        = 16;
    localparam int ELEM_WIDTH = 16;
    localparam int IDX_W      = $clog2(DIM);
    localparam int PROD_W     = 2 * ELEM_WIDTH;
    localparam int ACC_W      = PROD_W + IDX_W;

    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_B  = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    typedef struct packed {
        logic [1:0]                    op;
        logic [3:0]                    row;
        logic [3:0]                    col;
        logic signed [ELEM_WIDTH-1:0]  elem_value;
    } t_in_req;

    typedef struct packed {
        logic [3:0]               out_row;
        logic [3:0]               out_col;
        logic signed [ACC_W-1:0]  out_value;
        logic                     last;
    } t_out_req;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

endpackage

// ===== design/mmm_if.sv =====
// Valid/ready stream interfaces for the request and result channels.
interface mmm_in_if;
    logic             valid;
    logic             ready;
    mmm_pkg::t_in_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mmm_out_if;
    logic              valid;
    logic              ready;
    mmm_pkg::t_out_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/mmm_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module mmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== design/matrix_matrix_multiply_top.sv =====
// Top level of the dense square matrix multiply engine.
//
// The block keeps two DIM x DIM matrices of signed Q8.8 elements. A load
// request (op 0 for A, op 1 for B) writes one element; one load is taken
// per clock while the block is idle. A compute request (op 2) names product
// row i; the block then returns DIM results C[i][j] = sum_k A[i][k]*B[k][j],
// one per column j in rising order, as exact signed Q20.16 values with last
// set on column DIM-1. A is one RAM of DIM*DIM entries; B is split into DIM
// column RAMs so that a whole row of B is read each cycle and DIM multiply-
// accumulate units work in parallel. A compute therefore occupies the block
// while it issues the DIM reads, waits for the registered read data of the
// last one and then delivers the DIM results, which can stall on the result
// side; no new request is taken until the last result of the row has been
// delivered. Loads and computes with an index at or beyond DIM, and the
// unused op 3, are dropped without results. Memory contents are undefined
// after reset; a compute must only touch written entries.
module matrix_matrix_multiply_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mmm_in_if.sink       i_in,
    mmm_out_if.source    o_out
);

    localparam int DIM   = mmm_pkg::DIM;
    localparam int EW    = mmm_pkg::ELEM_WIDTH;
    localparam int IDX_W = mmm_pkg::IDX_W;
    localparam int ACC_W = mmm_pkg::ACC_W;

    mmm_pkg::t_state r_state, n_state;
    logic [IDX_W:0]   r_k, n_k;       // read step, counts to DIM
    logic [IDX_W-1:0] r_j, n_j;       // output column
    logic [IDX_W-1:0] r_row;          // product row in flight
    logic             r_rd_vld;       // RAM data for a step is present

    logic signed [ACC_W-1:0] r_acc [DIM];

    logic           w_accept;
    logic           w_row_ok;
    logic           w_col_ok;
    logic           w_load_a;
    logic           w_load_b;
    logic           w_start;
    logic           w_issue;
    logic [EW-1:0]  w_a_rdata;
    logic [EW-1:0]  w_b_rdata [DIM];
    logic signed [2*EW-1:0] w_prod [DIM];

    // Accept requests only while idle.
    assign i_in.ready = (r_state == mmm_pkg::S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_row_ok = (int'(i_in.data.row) < DIM);
    assign w_col_ok = (int'(i_in.data.col) < DIM);
    assign w_load_a = w_accept && (i_in.data.op == mmm_pkg::OP_LOAD_A) && w_row_ok && w_col_ok;
    assign w_load_b = w_accept && (i_in.data.op == mmm_pkg::OP_LOAD_B) && w_row_ok && w_col_ok;
    assign w_start  = w_accept && (i_in.data.op == mmm_pkg::OP_COMPUTE) && w_row_ok;

    // Issue one read of A[i][k] and row k of B per cycle while running.
    assign w_issue = (r_state == mmm_pkg::S_RUN) && (int'(r_k) < DIM);

    mmm_ram #(
        .WIDTH (EW),
        .DEPTH (DIM * DIM)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_load_a),
        .i_waddr ({i_in.data.row[IDX_W-1:0], i_in.data.col[IDX_W-1:0]}),
        .i_wdata (i_in.data.elem_value),
        .i_raddr ({r_row, r_k[IDX_W-1:0]}),
        .o_rdata (w_a_rdata)
    );

    // One RAM per B column, addressed by row.
    for (genvar g = 0; g < DIM; g++) begin : g_bcol
        logic w_we;
        assign w_we = w_load_b && (int'(i_in.data.col) == g);

        mmm_ram #(
            .WIDTH (EW),
            .DEPTH (DIM)
        ) u_ram_b (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (i_in.data.row[IDX_W-1:0]),
            .i_wdata (i_in.data.elem_value),
            .i_raddr (r_k[IDX_W-1:0]),
            .o_rdata (w_b_rdata[g])
        );
    end

    // Sequencer: run DIM reads, wait for the last data, then emit the row.
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_j     = r_j;
        unique case (r_state)
            mmm_pkg::S_IDLE: begin
                n_k = '0;
                n_j = '0;
                if (w_start) begin
                    n_state = mmm_pkg::S_RUN;
                end
            end
            mmm_pkg::S_RUN: begin
                if (int'(r_k) == DIM) begin
                    n_state = mmm_pkg::S_EMIT;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            mmm_pkg::S_EMIT: begin
                if (o_out.ready) begin
                    n_j = r_j + 1'b1;
                    if (int'(r_j) == DIM - 1) begin
                        n_state = mmm_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = mmm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mmm_pkg::S_IDLE;
            r_k      <= '0;
            r_j      <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_j      <= n_j;
            r_rd_vld <= w_issue;
        end
    end

    // One exact element product per column, A[i][k] times B[k][j].
    always_comb begin
        for (int j = 0; j < DIM; j++) begin
            w_prod[j] = $signed(w_a_rdata) * $signed(w_b_rdata[j]);
        end
    end

    // Hold the product row and clear or advance the accumulators.
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_row <= i_in.data.row[IDX_W-1:0];
        end
        for (int j = 0; j < DIM; j++) begin
            if (w_start) begin
                r_acc[j] <= '0;
            end else if (r_rd_vld) begin
                r_acc[j] <= r_acc[j] + ACC_W'(w_prod[j]);
            end
        end
    end

    // Result channel, driven straight from the held accumulators.
    assign o_out.valid          = (r_state == mmm_pkg::S_EMIT);
    assign o_out.data.out_row   = 4'(r_row);
    assign o_out.data.out_col   = 4'(r_j);
    assign o_out.data.out_value = r_acc[r_j];
    assign o_out.data.last      = (int'(r_j) == DIM - 1);

endmodule
